// ===== src/vci_pkg.sv =====
// shared constants and types of the voltage to charge interpolator
package vci_pkg;

    localparam int TABLE_POINTS_DEF = 11;
    localparam int IDX_W            = 4;
    localparam int VOLT_W           = 16;
    localparam int PCT_W            = 7;
    localparam int QUOT_W           = 4;
    localparam int NUM_W            = VOLT_W + QUOT_W;

    localparam logic             REQ_LOAD     = 1'b0;
    localparam logic             REQ_ESTIMATE = 1'b1;
    localparam logic [PCT_W-1:0] PERCENT_ZERO = 7'd0;
    localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

    typedef logic [VOLT_W-1:0] t_volt;
    typedef logic [PCT_W-1:0]  t_pct;
    typedef logic [QUOT_W-1:0] t_quot;

    typedef struct packed {
        logic  done;
        t_quot quot;
    } t_div_rsp;

endpackage

// ===== src/vci_req_if.sv =====
// request channel: table load or charge estimate
interface vci_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [vci_pkg::IDX_W-1:0]       point_index;
    logic [vci_pkg::VOLT_W-1:0]      point_voltage;
    logic [vci_pkg::VOLT_W-1:0]      cell_voltage;

    modport source (
        output valid, req_type, point_index, point_voltage, cell_voltage,
        input  ready
    );
    modport sink (
        input  valid, req_type, point_index, point_voltage, cell_voltage,
        output ready
    );
endinterface

// ===== src/vci_rsp_if.sv =====
// response channel: charge percentage
interface vci_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [vci_pkg::PCT_W-1:0]  charge_percent;

    modport source (
        output valid, charge_percent,
        input  ready
    );
    modport sink (
        input  valid, charge_percent,
        output ready
    );
endinterface

// ===== src/vci_table.sv =====
// table of voltage points with one write port and a registered read port
module vci_table #(
    parameter int TABLE_POINTS = vci_pkg::TABLE_POINTS_DEF,
    parameter int AW           = $clog2(TABLE_POINTS)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_idx,
    input  logic [vci_pkg::VOLT_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_idx,
    output logic [vci_pkg::VOLT_W-1:0] o_rd_data
);
    import vci_pkg::*;

    t_volt r_mem [TABLE_POINTS];
    t_volt r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/vci_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module vci_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vci_pkg::VOLT_W-1:0] i_diff,
    input  logic [vci_pkg::VOLT_W-1:0] i_den,
    output vci_pkg::t_div_rsp          o_rsp
);
    import vci_pkg::*;

    logic [NUM_W-1:0]          r_rem;
    logic [NUM_W-1:0]          n_rem;
    logic [NUM_W-1:0]          r_dsr;
    logic [NUM_W-1:0]          n_dsr;
    t_quot                     r_quot;
    t_quot                     n_quot;
    logic [$clog2(QUOT_W)-1:0] r_cnt;
    logic [$clog2(QUOT_W)-1:0] n_cnt;
    logic                      r_busy;
    logic                      n_busy;
    logic                      r_done;
    logic                      n_done;
    logic                      fits;

    assign fits = (r_rem >= r_dsr);

    always_comb begin
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // numerator is ten times the difference
            n_rem  = {{QUOT_W{1'b0}}, i_diff} << 3;
            n_rem  = n_rem + ({{QUOT_W{1'b0}}, i_diff} << 1);
            n_dsr  = {{QUOT_W{1'b0}}, i_den} << (QUOT_W - 1);
            n_quot = '0;
            n_cnt  = '1;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = r_rem - r_dsr;
            end
            n_quot = {r_quot[QUOT_W-2:0], fits};
            n_dsr  = r_dsr >> 1;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== src/voltage_to_charge_interpolator.sv =====
// voltage to charge interpolator: table scan, serial division, output register
// load transfer: written in the transfer cycle if the index is in the table, no result, ready again at once
// estimate transfer: table scan one point per cycle, then serial divide for a hit above point 0
// estimate result: 0 at or below point 0, 100 above the last point, else interpolated between two points
// one estimate in flight at a time; a waiting result does not block the next transfer
// reset: synchronous active low, clears control and output valid; table undefined until loaded
module voltage_to_charge_interpolator #(
    parameter int TABLE_POINTS = vci_pkg::TABLE_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vci_req_if.sink   i_req,
    vci_rsp_if.source o_rsp
);
    import vci_pkg::*;

    localparam int AW = $clog2(TABLE_POINTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_POINTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_iss;
    logic          n_iss;
    logic [AW-1:0] r_scan_addr;
    logic [AW-1:0] n_scan_addr;
    logic          r_cmp_vld;
    logic          n_cmp_vld;
    logic [AW-1:0] r_cmp_idx;
    logic [AW-1:0] n_cmp_idx;
    t_volt         r_volt;
    t_volt         n_volt;
    t_volt         r_prev;
    t_volt         n_prev;
    t_volt         r_diff;
    t_volt         n_diff;
    t_volt         r_den;
    t_volt         n_den;
    t_pct          r_base;
    t_pct          n_base;
    t_pct          r_res;
    t_pct          n_res;
    logic          r_div_go;
    logic          n_div_go;
    logic          r_out_valid;
    logic          n_out_valid;
    t_pct          r_out_pct;
    t_pct          n_out_pct;

    logic          req_xfer;
    logic          wr_en;
    t_volt         rd_data;
    t_div_rsp      div_rsp;
    t_pct          idx_lo;

    assign req_xfer = i_req.valid && i_req.ready;
    assign wr_en    = req_xfer && (i_req.req_type == REQ_LOAD)
                   && ({1'b0, i_req.point_index} < 5'(TABLE_POINTS));
    assign idx_lo   = PCT_W'(r_cmp_idx - 1'b1);

    vci_table #(
        .TABLE_POINTS (TABLE_POINTS),
        .AW           (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (i_req.point_index[AW-1:0]),
        .i_wr_data (i_req.point_voltage),
        .i_rd_idx  (r_scan_addr),
        .o_rd_data (rd_data)
    );

    vci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_diff  (r_diff),
        .i_den   (r_den),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_iss       = 1'b0;
        n_scan_addr = r_scan_addr;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_scan_addr;
        n_volt      = r_volt;
        n_prev      = r_prev;
        n_diff      = r_diff;
        n_den       = r_den;
        n_base      = r_base;
        n_res       = r_res;
        n_div_go    = 1'b0;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_pct   = r_out_pct;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer && (i_req.req_type == REQ_ESTIMATE)) begin
                    n_volt      = i_req.cell_voltage;
                    n_scan_addr = '0;
                    n_iss       = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                n_iss     = r_iss && (r_scan_addr != LAST_IDX);
                n_cmp_vld = r_iss;
                if (r_iss) begin
                    n_scan_addr = r_scan_addr + 1'b1;
                end
                if (r_cmp_vld) begin
                    if (r_volt <= rd_data) begin
                        n_iss     = 1'b0;
                        n_cmp_vld = 1'b0;
                        if (r_cmp_idx == '0) begin
                            n_res   = PERCENT_ZERO;
                            n_state = S_FIN;
                        end else begin
                            n_diff   = r_volt - r_prev;
                            n_den    = rd_data - r_prev;
                            n_base   = (idx_lo << 3) + (idx_lo << 1);
                            n_div_go = 1'b1;
                            n_state  = S_DIV;
                        end
                    end else begin
                        n_prev = rd_data;
                        if (r_cmp_idx == LAST_IDX) begin
                            n_res   = PERCENT_FULL;
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = r_base + PCT_W'(div_rsp.quot);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_pct   = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss       <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan_addr <= '0;
        end else begin
            r_state     <= n_state;
            r_iss       <= n_iss;
            r_cmp_vld   <= n_cmp_vld;
            r_div_go    <= n_div_go;
            r_out_valid <= n_out_valid;
            r_scan_addr <= n_scan_addr;
        end
        r_cmp_idx <= n_cmp_idx;
        r_volt    <= n_volt;
        r_prev    <= n_prev;
        r_diff    <= n_diff;
        r_den     <= n_den;
        r_base    <= n_base;
        r_res     <= n_res;
        r_out_pct <= n_out_pct;
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.charge_percent = r_out_pct;

endmodule

// ===== tb/tb_voltage_to_charge_interpolator.sv =====
// testbench of the voltage to charge interpolator: table loads and charge estimates
`timescale 1ns / 100ps

module tb_voltage_to_charge_interpolator;

    import vci_pkg::*;

    localparam int TABLE_POINTS = TABLE_POINTS_DEF;
    localparam int PCT_STEP     = 10;
    localparam int VOLT_MAX     = (1 << VOLT_W) - 1;
    localparam int ITEM_TARGET  = 1850;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE       = 40;

    typedef struct {
        logic               req_type;
        logic [IDX_W-1:0]   point_index;
        t_volt              point_voltage;
        t_volt              cell_voltage;
    } t_req_item;

    logic i_clk;
    logic i_rst_n;

    vci_req_if req_bus ();
    vci_rsp_if rsp_bus ();

    voltage_to_charge_interpolator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_req_item req_backlog[$];
    t_pct      pending_percent[$];
    t_volt     soc_points[TABLE_POINTS];
    int        gen_points[TABLE_POINTS];
    t_req_item cur_req;
    int        req_gap;
    int        rsp_gap;
    int        accepted_reqs;
    int        error_count;
    logic      hold_rsp;

    always #1 i_clk = ~i_clk;

    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_LOAD;
        req_bus.point_index   = '0;
        req_bus.point_voltage = '0;
        req_bus.cell_voltage  = '0;
        rsp_bus.ready         = 1'b0;
        hold_rsp              = 1'b0;
        req_gap               = 0;
        rsp_gap               = 0;
        accepted_reqs         = 0;
        error_count           = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_pct estimate_percent(t_volt v);
        int unsigned hi;
        int unsigned lo;
        for (int k = 0; k < TABLE_POINTS; k++) begin
            hi = soc_points[k];
            if (v <= hi) begin
                if (k == 0) return PERCENT_ZERO;
                lo = soc_points[k-1];
                return t_pct'((k - 1) * PCT_STEP + (PCT_STEP * (v - lo)) / (hi - lo));
            end
        end
        return PERCENT_FULL;
    endfunction

    function automatic bit idling_allowed();
        return req_backlog.size() >= QUIET_TAIL;
    endfunction

    // idle rate changes with the phase of the run: none, light, heavy
    function automatic int idle_pct();
        case ((req_backlog.size() / 250) % 3)
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_request(logic rt, int idx, int pv, int cv);
        t_req_item it;
        it.req_type      = rt;
        it.point_index   = idx[IDX_W-1:0];
        it.point_voltage = pv[VOLT_W-1:0];
        it.cell_voltage  = cv[VOLT_W-1:0];
        req_backlog.push_back(it);
        if (rt == REQ_LOAD && idx < TABLE_POINTS) gen_points[idx] = pv;
    endtask

    task automatic load_table(bit sorted);
        int acc;
        int val;
        acc = $urandom_range(0, 9000);
        for (int k = 0; k < TABLE_POINTS; k++) begin
            if (sorted) begin
                val = acc;
                acc = acc + $urandom_range(0, 6500);
                if (acc > VOLT_MAX) acc = VOLT_MAX;
            end else begin
                val = $urandom_range(0, VOLT_MAX);
            end
            push_request(REQ_LOAD, k, val, $urandom_range(0, VOLT_MAX));
        end
    endtask

    function automatic int clamp_volt(int v);
        if (v < 0) return 0;
        if (v > VOLT_MAX) return VOLT_MAX;
        return v;
    endfunction

    task automatic push_estimate();
        int sel;
        int k;
        int cv;
        int a;
        int b;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, TABLE_POINTS - 1);
        if (sel < 25) begin
            cv = $urandom_range(0, VOLT_MAX);
        end else if (sel < 65) begin
            cv = clamp_volt(gen_points[k] + $urandom_range(0, 4) - 2);
        end else if (k < TABLE_POINTS - 1) begin
            a  = gen_points[k];
            b  = gen_points[k+1];
            cv = (a < b) ? $urandom_range(a, b) : $urandom_range(b, a);
        end else begin
            cv = clamp_volt(gen_points[k] + $urandom_range(1, 300));
        end
        push_request(REQ_ESTIMATE, $urandom_range(0, 15), $urandom_range(0, VOLT_MAX), cv);
    endtask

    initial begin
        int sel;
        // sorted table with a low first point, out-of-range loads, then the corner estimates
        push_request(REQ_LOAD, 0, 100, VOLT_MAX);
        for (int k = 1; k < TABLE_POINTS; k++) push_request(REQ_LOAD, k, k * 6000, 0);
        push_request(REQ_LOAD, 15, VOLT_MAX, 0);
        push_request(REQ_LOAD, 11, 0, VOLT_MAX);
        push_request(REQ_ESTIMATE, 0, 0, 0);
        push_request(REQ_ESTIMATE, 0, 0, 100);
        push_request(REQ_ESTIMATE, 0, 0, 101);
        push_request(REQ_ESTIMATE, 15, VOLT_MAX, 30001);
        push_request(REQ_ESTIMATE, 0, 0, 60000);
        push_request(REQ_ESTIMATE, 0, 0, VOLT_MAX);
        // point below its predecessor
        push_request(REQ_LOAD, 3, 1000, 0);
        push_request(REQ_ESTIMATE, 0, 0, 5000);
        push_request(REQ_ESTIMATE, 0, 0, 8000);
        push_request(REQ_ESTIMATE, 0, 0, 13000);
        // full-scale ends of the table
        push_request(REQ_LOAD, 0, 0, 0);
        push_request(REQ_LOAD, 10, VOLT_MAX, 0);
        push_request(REQ_ESTIMATE, 0, 0, 0);
        push_request(REQ_ESTIMATE, 0, 0, VOLT_MAX);
        push_request(REQ_ESTIMATE, 0, 0, 59999);

        while (req_backlog.size() < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) load_table($urandom_range(0, 99) < 80);
            else if (sel < 15) push_request(REQ_LOAD, $urandom_range(0, 15),
                                            $urandom_range(0, VOLT_MAX),
                                            $urandom_range(0, VOLT_MAX));
            else push_estimate();
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                accepted_reqs++;
                if (cur_req.req_type == REQ_LOAD) begin
                    if (cur_req.point_index < TABLE_POINTS)
                        soc_points[cur_req.point_index] = cur_req.point_voltage;
                end else begin
                    pending_percent.push_back(estimate_percent(cur_req.cell_voltage));
                end
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_bus.valid <= 1'b0;
                end else if (req_backlog.size() > 0 && idling_allowed() &&
                             $urandom_range(0, 99) < idle_pct()) begin
                    req_gap = $urandom_range(0, 12);
                    req_bus.valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    cur_req = req_backlog.pop_front();
                    req_bus.req_type      <= cur_req.req_type;
                    req_bus.point_index   <= cur_req.point_index;
                    req_bus.point_voltage <= cur_req.point_voltage;
                    req_bus.cell_voltage  <= cur_req.cell_voltage;
                    req_bus.valid         <= 1'b1;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_pct want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
                if (pending_percent.size() == 0) begin
                    report_mismatch("unexpected result, charge_percent",
                                    rsp_bus.charge_percent, -1);
                end else begin
                    want = pending_percent.pop_front();
                    if (rsp_bus.charge_percent !== want)
                        report_mismatch("charge_percent", rsp_bus.charge_percent, want);
                end
            end
            if (hold_rsp) begin
                rsp_bus.ready <= 1'b0;
            end else if (rsp_gap > 0) begin
                rsp_gap--;
                rsp_bus.ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 99) < idle_pct()) begin
                rsp_gap = $urandom_range(0, 12);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up into the request side
    initial begin
        wait (accepted_reqs >= HOLD_AFTER);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    initial begin
        int waited;
        waited = 0;
        @(posedge i_rst_n);
        while (req_backlog.size() != 0 || req_bus.valid) @(posedge i_clk);
        while (pending_percent.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_percent.size() != 0)
            report_mismatch("results never delivered, count", pending_percent.size(), 0);
        if (error_count == 0) begin
            $display("tb_voltage_to_charge_interpolator: done, clean");
        end else begin
            $display("tb_voltage_to_charge_interpolator: done, errors");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("tb_voltage_to_charge_interpolator: done, errors");
        $finish;
    end

endmodule
